// ===== hw/rtl/bew_pkg.sv =====
// Shared constants and types for the Bernoulli edge weight pipeline.
package bew_pkg;

  localparam int DATA_W = 24;
  localparam int FRAC_W = 16;
  localparam int OUT_W  = DATA_W - 1;
  localparam int BAND_W = 8;

  // exponential datapath: unsigned fraction with QP bits
  localparam int QP    = 56;
  localparam int TS_W  = FRAC_W + 6;        // |x| below the cutoff of 48.0
  localparam int N_W   = 7;                 // shift count n, at most 69
  localparam int TERMS = 16;                // later series terms are always zero
  localparam int REM_W = TS_W + QP - FRAC_W;
  localparam int Q_W   = FRAC_W + 3;

  localparam logic [QP-1:0]     LN2   = 56'hB17217F7D1CF7A;
  localparam logic [QP:0]       ONE   = (QP + 1)'(1) << QP;
  localparam logic [DATA_W-1:0] T_CUT = DATA_W'(48) << FRAC_W;

  // n = floor(t * 2^(QP-FRAC_W) / LN2) estimated as (t * K_RECIP) >> K_SH
  localparam int K_SH = 40;
  localparam int K_W  = K_SH - FRAC_W + 2;
  localparam logic [K_W-1:0] K_RECIP =
    K_W'((128'd1 << (K_SH + QP - FRAC_W)) / 128'(LN2));

  typedef struct packed {
    logic              neg;
    logic [DATA_W-1:0] t;
    logic              clip;
    logic              near;
    logic              big;
  } side_t;

endpackage

// ===== hw/rtl/bew_reduce.sv =====
// Front stages: difference, clamp, magnitude, and range reduction t = n*ln2 + r.
module bew_reduce (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [bew_pkg::DATA_W-1:0]  v_here,
  input  logic [bew_pkg::DATA_W-1:0]  v_prev,
  input  logic [bew_pkg::BAND_W-1:0]  band,
  output logic                        out_valid,
  output bew_pkg::side_t              out_side,
  output logic [bew_pkg::N_W-1:0]     out_n,
  output logic [bew_pkg::QP-1:0]      out_r
);

  localparam int DW   = bew_pkg::DATA_W;
  localparam int QP   = bew_pkg::QP;
  localparam int TS_W = bew_pkg::TS_W;
  localparam int TP_W = bew_pkg::TS_W + bew_pkg::QP - bew_pkg::FRAC_W;
  localparam int PR_W = bew_pkg::TS_W + bew_pkg::K_W;

  logic [DW:0]              diff;
  logic [DW-1:0]            x_sat;
  logic                     clip_sat;
  logic                     vld1;
  logic [DW-1:0]            x1;
  logic                     clip1;
  logic [DW-1:0]            t_abs;
  logic                     vld2;
  bew_pkg::side_t           side2;
  logic [PR_W-1:0]          prod;
  logic                     vld3;
  bew_pkg::side_t           side3;
  logic [bew_pkg::N_W-1:0]  n3;
  logic [TP_W-1:0]          tp;
  logic [TP_W:0]            r_full;
  logic                     vld4;
  bew_pkg::side_t           side4;
  logic [bew_pkg::N_W-1:0]  n4;
  logic [QP:0]              r4;

  always_comb begin
    diff     = {v_here[DW-1], v_here} - {v_prev[DW-1], v_prev};
    clip_sat = diff[DW] != diff[DW-1];
    if (clip_sat) begin
      x_sat = diff[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      x_sat = diff[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= in_valid;
    end
    x1    <= x_sat;
    clip1 <= clip_sat;
  end

  // most negative x maps to 2^(DW-1), still fits unsigned
  assign t_abs = x1[DW-1] ? (DW'(0) - x1) : x1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else begin
      vld2 <= vld1;
    end
    side2.neg  <= x1[DW-1];
    side2.t    <= t_abs;
    side2.clip <= clip1;
    side2.near <= t_abs <= DW'(band);
    side2.big  <= t_abs >= bew_pkg::T_CUT;
  end

  assign prod = PR_W'(side2.t[TS_W-1:0]) * PR_W'(bew_pkg::K_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else begin
      vld3 <= vld2;
    end
    side3 <= side2;
    n3    <= prod[bew_pkg::K_SH +: bew_pkg::N_W];
  end

  // estimate is n or n-1
  assign tp     = {side3.t[TS_W-1:0], {(QP - bew_pkg::FRAC_W){1'b0}}};
  assign r_full = (TP_W + 1)'(tp) - (TP_W + 1)'(n3) * (TP_W + 1)'(bew_pkg::LN2);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld4 <= 1'b0;
    end else begin
      vld4 <= vld3;
    end
    side4 <= side3;
    n4    <= n3;
    r4    <= r_full[QP:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld4;
    end
    out_side <= side4;
    if (r4 >= (QP + 1)'(bew_pkg::LN2)) begin
      out_r <= QP'(r4 - (QP + 1)'(bew_pkg::LN2));
      out_n <= n4 + bew_pkg::N_W'(1);
    end else begin
      out_r <= r4[QP-1:0];
      out_n <= n4;
    end
  end

`ifndef ASSERT_OFF
  a_rem_reduced: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_side.big |-> out_r < bew_pkg::LN2)
    else $error("range reduction left r at or above ln2");
`endif

endmodule

// ===== hw/rtl/bew_taylor.sv =====
// Series unit: d = 1 - e^-r as an alternating Taylor sum, four stages per term.
module bew_taylor (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  bew_pkg::side_t           in_side,
  input  logic [bew_pkg::N_W-1:0]  in_n,
  input  logic [bew_pkg::QP-1:0]   in_r,
  output logic                     out_valid,
  output bew_pkg::side_t           out_side,
  output logic [bew_pkg::N_W-1:0]  out_n,
  output logic [bew_pkg::QP-1:0]   out_d
);

  localparam int QP    = bew_pkg::QP;
  localparam int HW    = QP / 2;
  localparam int TERMS = bew_pkg::TERMS;
  localparam int RC_SH = 60;
  localparam int RC_W  = 60;
  localparam int RH    = RC_W / 2;
  localparam bit LAST_ADD = (TERMS % 2) == 1;

  logic                    vld_s  [1:TERMS];
  bew_pkg::side_t          side_s [1:TERMS];
  logic [bew_pkg::N_W-1:0] n_s    [1:TERMS];
  logic [QP-1:0]           r_s    [1:TERMS];
  logic [QP-1:0]           term_s [1:TERMS];
  logic [QP-1:0]           dsum_s [1:TERMS];

  assign vld_s[1]  = in_valid;
  assign side_s[1] = in_side;
  assign n_s[1]    = in_n;
  assign r_s[1]    = in_r;
  assign term_s[1] = in_r;
  assign dsum_s[1] = '0;

  for (genvar g = 1; g < TERMS; g++) begin : g_term
    localparam int DIV = g + 1;
    // exact floor(P/DIV) for P < 2^QP
    localparam logic [RC_W-1:0] RECIP =
      RC_W'(((64'd1 << RC_SH) + 64'(DIV) - 64'd1) / 64'(DIV));
    localparam bit ADD = (g % 2) == 1;

    logic                    va, vb, vc, vd;
    bew_pkg::side_t          sa, sb, sc, sd;
    logic [bew_pkg::N_W-1:0] na, nb, nc, nd;
    logic [QP-1:0]           ra, rb, rc, rd;
    logic [QP-1:0]           da, db, dc, dd;
    logic [2*HW-1:0]         hh, hl, lh, ll;
    logic [2*QP:0]           sum_b;
    logic [QP-1:0]           pb;
    logic [HW+RH-1:0]        ch, cm1, cm2, cl;
    logic [QP+RC_W:0]        sum_d;
    logic [QP-1:0]           tnext;

    always_ff @(posedge clk) begin
      if (rst) begin
        va <= 1'b0;
      end else begin
        va <= vld_s[g];
      end
      sa <= side_s[g];
      na <= n_s[g];
      ra <= r_s[g];
      da <= ADD ? dsum_s[g] + term_s[g] : dsum_s[g] - term_s[g];
      hh <= (2*HW)'(term_s[g][QP-1:HW]) * (2*HW)'(r_s[g][QP-1:HW]);
      hl <= (2*HW)'(term_s[g][QP-1:HW]) * (2*HW)'(r_s[g][HW-1:0]);
      lh <= (2*HW)'(term_s[g][HW-1:0])  * (2*HW)'(r_s[g][QP-1:HW]);
      ll <= (2*HW)'(term_s[g][HW-1:0])  * (2*HW)'(r_s[g][HW-1:0]);
    end

    assign sum_b = (2*QP + 1)'({hh, ll})
                 + (((2*QP + 1)'(hl) + (2*QP + 1)'(lh)) << HW);

    always_ff @(posedge clk) begin
      if (rst) begin
        vb <= 1'b0;
      end else begin
        vb <= va;
      end
      sb <= sa;
      nb <= na;
      rb <= ra;
      db <= da;
      pb <= sum_b[QP +: QP];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vc <= 1'b0;
      end else begin
        vc <= vb;
      end
      sc  <= sb;
      nc  <= nb;
      rc  <= rb;
      dc  <= db;
      ch  <= (HW+RH)'(pb[QP-1:HW]) * (HW+RH)'(RECIP[RC_W-1:RH]);
      cm1 <= (HW+RH)'(pb[QP-1:HW]) * (HW+RH)'(RECIP[RH-1:0]);
      cm2 <= (HW+RH)'(pb[HW-1:0])  * (HW+RH)'(RECIP[RC_W-1:RH]);
      cl  <= (HW+RH)'(pb[HW-1:0])  * (HW+RH)'(RECIP[RH-1:0]);
    end

    assign sum_d = ((QP + RC_W + 1)'(ch) << (HW + RH))
                 + ((QP + RC_W + 1)'(cm1) << HW)
                 + ((QP + RC_W + 1)'(cm2) << RH)
                 + (QP + RC_W + 1)'(cl);
    assign tnext = sum_d[RC_SH +: QP];

    always_ff @(posedge clk) begin
      if (rst) begin
        vd <= 1'b0;
      end else begin
        vd <= vc;
      end
      sd <= sc;
      nd <= nc;
      rd <= rc;
      dd <= dc;
    end

    logic [QP-1:0] td;
    always_ff @(posedge clk) begin
      td <= tnext;
    end

    assign vld_s[g+1]  = vd;
    assign side_s[g+1] = sd;
    assign n_s[g+1]    = nd;
    assign r_s[g+1]    = rd;
    assign term_s[g+1] = td;
    assign dsum_s[g+1] = dd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld_s[TERMS];
    end
    out_side <= side_s[TERMS];
    out_n    <= n_s[TERMS];
    out_d    <= LAST_ADD ? dsum_s[TERMS] + term_s[TERMS]
                         : dsum_s[TERMS] - term_s[TERMS];
  end

endmodule

// ===== hw/rtl/bew_divide.sv =====
// Back stages: E = e^-t, numerator t*E, denominator 1-E, and restoring division.
module bew_divide (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  bew_pkg::side_t           in_side,
  input  logic [bew_pkg::N_W-1:0]  in_n,
  input  logic [bew_pkg::QP-1:0]   in_d,
  output logic                     out_valid,
  output bew_pkg::side_t           out_side,
  output logic [bew_pkg::Q_W-1:0]  out_bs
);

  localparam int QP    = bew_pkg::QP;
  localparam int HW    = QP / 2;
  localparam int E_W   = QP + 1;
  localparam int TS_W  = bew_pkg::TS_W;
  localparam int REM_W = bew_pkg::REM_W;
  localparam int Q_W   = bew_pkg::Q_W;
  localparam int S_W   = TS_W + E_W;
  localparam int INT_B = 2;   // integer quotient bits

  logic                  vld1, vld2, vld3;
  bew_pkg::side_t        side1, side2, side3;
  logic [E_W-1:0]        e1;
  logic [QP-1:0]         d1;
  logic                  nz1;
  logic [E_W-1:0]        den2;
  logic [TS_W+E_W-HW-1:0] pe_hi;
  logic [TS_W+HW-1:0]    pe_lo;
  logic [S_W-1:0]        num_sum;
  logic [REM_W-1:0]      num3;
  logic [E_W-1:0]        den3;
  logic                  dz3;

  logic                  vld_q  [0:Q_W];
  bew_pkg::side_t        side_q [0:Q_W];
  logic                  dz_q   [0:Q_W];
  logic [E_W-1:0]        den_q  [0:Q_W];
  logic [REM_W-1:0]      rem_q  [0:Q_W];
  logic [Q_W-1:0]        quo_q  [0:Q_W];
  logic [Q_W:0]          rnd;

  // shifts of 57 or more clear E
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= in_valid;
    end
    side1 <= in_side;
    e1    <= (bew_pkg::ONE - E_W'(in_d)) >> in_n;
    d1    <= in_d;
    nz1   <= in_n == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else begin
      vld2 <= vld1;
    end
    side2 <= side1;
    den2  <= nz1 ? E_W'(d1) : bew_pkg::ONE - e1;
    pe_hi <= (TS_W+E_W-HW)'(side1.t[TS_W-1:0]) * (TS_W+E_W-HW)'(e1[E_W-1:HW]);
    pe_lo <= (TS_W+HW)'(side1.t[TS_W-1:0]) * (TS_W+HW)'(e1[HW-1:0]);
  end

  assign num_sum = (S_W'(pe_hi) << HW) + S_W'(pe_lo);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else begin
      vld3 <= vld2;
    end
    side3 <= side2;
    num3  <= num_sum[bew_pkg::FRAC_W +: REM_W];
    den3  <= den2;
    dz3   <= den2 == '0;
  end

  assign vld_q[0]  = vld3;
  assign side_q[0] = side3;
  assign dz_q[0]   = dz3;
  assign den_q[0]  = den3;
  assign rem_q[0]  = num3;
  assign quo_q[0]  = '0;

  for (genvar j = 0; j < Q_W; j++) begin : g_div
    localparam bit FRAC_STEP = j >= INT_B;
    localparam int SH = FRAC_STEP ? 0 : INT_B - 1 - j;

    logic [REM_W-1:0] rem_in, dv;
    logic             qbit;
    logic             v;
    bew_pkg::side_t   s;
    logic             z;
    logic [E_W-1:0]   dn;
    logic [REM_W-1:0] rm;
    logic [Q_W-1:0]   qo;

    always_comb begin
      rem_in = FRAC_STEP ? (rem_q[j] << 1) : rem_q[j];
      dv     = REM_W'(den_q[j]) << SH;
      qbit   = rem_in >= dv;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v <= 1'b0;
      end else begin
        v <= vld_q[j];
      end
      s  <= side_q[j];
      z  <= dz_q[j];
      dn <= den_q[j];
      rm <= qbit ? rem_in - dv : rem_in;
      qo <= {quo_q[j][Q_W-2:0], qbit};
    end

    assign vld_q[j+1]  = v;
    assign side_q[j+1] = s;
    assign dz_q[j+1]   = z;
    assign den_q[j+1]  = dn;
    assign rem_q[j+1]  = rm;
    assign quo_q[j+1]  = qo;
  end

  // one extra quotient bit, round half up
  assign rnd = (Q_W + 1)'(quo_q[Q_W]) + (Q_W + 1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld_q[Q_W];
    end
    out_side <= side_q[Q_W];
    out_bs   <= dz_q[Q_W] ? (Q_W'(1) << bew_pkg::FRAC_W) : rnd[Q_W:1];
  end

`ifndef ASSERT_OFF
  a_int_quot: assert property (@(posedge clk) disable iff (rst)
    vld_q[INT_B] && !side_q[INT_B].big && !side_q[INT_B].near && !dz_q[INT_B]
      |-> rem_q[INT_B] < REM_W'(den_q[INT_B]))
    else $error("integer part of the weight quotient overflowed");
`endif

endmodule

// ===== hw/rtl/bernoulli_edge_weights_core.sv =====
// Top level: Scharfetter-Gummel Bernoulli edge weights, fully pipelined.
//
// Takes one word (v_here, v_prev) per clock: a word is taken when start is
// high and busy is low, and busy is high only during reset. The result comes
// out on b_pos, b_neg and clipped with done high for one cycle; there is no
// backpressure, so the receiver must take every result in that cycle. Most
// of the pipeline depth lies in the series unit, which spends four stages
// (two split multiplies) on each of 15 Taylor terms, and in the 19-stage
// restoring divider. The near-zero band is written through cfg_valid and
// cfg_ready and applies to words started with the write or after it.
module bernoulli_edge_weights_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [bew_pkg::DATA_W-1:0]  v_here,
  input  logic [bew_pkg::DATA_W-1:0]  v_prev,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bew_pkg::BAND_W-1:0]  cfg_data,
  output logic                        done,
  output logic [bew_pkg::OUT_W-1:0]   b_pos,
  output logic [bew_pkg::OUT_W-1:0]   b_neg,
  output logic                        clipped
);

  localparam int DW    = bew_pkg::DATA_W;
  localparam int OUT_W = bew_pkg::OUT_W;
  localparam logic [DW:0] OMAX_W = (DW + 1)'({OUT_W{1'b1}});
  localparam logic [DW:0] ONE_W  = (DW + 1)'(1) << bew_pkg::FRAC_W;

  logic [bew_pkg::BAND_W-1:0] band;

  logic                    red_valid;
  bew_pkg::side_t          red_side;
  logic [bew_pkg::N_W-1:0] red_n;
  logic [bew_pkg::QP-1:0]  red_r;

  logic                    ser_valid;
  bew_pkg::side_t          ser_side;
  logic [bew_pkg::N_W-1:0] ser_n;
  logic [bew_pkg::QP-1:0]  ser_d;

  logic                    div_valid;
  bew_pkg::side_t          div_side;
  logic [bew_pkg::Q_W-1:0] div_bs;

  logic [DW:0]             b_small, b_large, p_w, n_w;
  logic                    clip_w;
  logic                    near_q, neg_q;
  logic [DW-1:0]           t_q;

  assign busy      = rst;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      band <= '0;
    end else if (cfg_valid && cfg_ready) begin
      band <= cfg_data;
    end
  end

  bew_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .v_here    (v_here),
    .v_prev    (v_prev),
    .band      (band),
    .out_valid (red_valid),
    .out_side  (red_side),
    .out_n     (red_n),
    .out_r     (red_r)
  );

  bew_taylor u_taylor (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (red_valid),
    .in_side   (red_side),
    .in_n      (red_n),
    .in_r      (red_r),
    .out_valid (ser_valid),
    .out_side  (ser_side),
    .out_n     (ser_n),
    .out_d     (ser_d)
  );

  bew_divide u_divide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ser_valid),
    .in_side   (ser_side),
    .in_n      (ser_n),
    .in_d      (ser_d),
    .out_valid (div_valid),
    .out_side  (div_side),
    .out_bs    (div_bs)
  );

  // larger weight is B(t) + t; the sign of x picks which side gets it
  always_comb begin
    b_small = div_side.big ? '0 : (DW + 1)'(div_bs);
    b_large = b_small + (DW + 1)'(div_side.t);
    p_w     = div_side.neg ? b_large : b_small;
    n_w     = div_side.neg ? b_small : b_large;
    clip_w  = div_side.clip;
    if (div_side.near) begin
      p_w = ONE_W;
      n_w = ONE_W;
    end
    if (p_w > OMAX_W) begin
      p_w    = OMAX_W;
      clip_w = 1'b1;
    end
    if (n_w > OMAX_W) begin
      n_w    = OMAX_W;
      clip_w = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_valid;
    end
    b_pos   <= p_w[OUT_W-1:0];
    b_neg   <= n_w[OUT_W-1:0];
    clipped <= clip_w;
    near_q  <= div_side.near;
    neg_q   <= div_side.neg;
    t_q     <= div_side.t;
  end

`ifndef ASSERT_OFF
  a_near_one: assert property (@(posedge clk) disable iff (rst)
    done && near_q |-> b_pos == OUT_W'(ONE_W) && b_neg == OUT_W'(ONE_W))
    else $error("near-zero word did not give unit weights");

  a_gap_is_t: assert property (@(posedge clk) disable iff (rst)
    done && !near_q && !clipped |->
      (neg_q ? (DW'(b_pos) - DW'(b_neg)) : (DW'(b_neg) - DW'(b_pos))) == t_q)
    else $error("weights do not differ by |x|");
`endif

endmodule

// ===== test/tb_bernoulli_edge_weights_core.sv =====
// Testbench for bernoulli_edge_weights_core: directed table plus random words checked by a predictor.
module tb_bernoulli_edge_weights_core;

  localparam int          DATA_W      = bew_pkg::DATA_W;
  localparam int          FRAC_W      = bew_pkg::FRAC_W;
  localparam int          OUT_W       = bew_pkg::OUT_W;
  localparam int          BAND_W      = bew_pkg::BAND_W;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          DRAIN_WAIT  = 100;  // pipeline is 90 deep
  localparam int          PHASE_WORDS = 400;
  localparam logic [63:0] LN2_FX      = 64'h00B17217F7D1CF7A;
  localparam logic [63:0] ONE_FX      = 64'd1 << 56;
  localparam logic [63:0] UNITY       = 64'd1 << FRAC_W;
  localparam logic [63:0] OUT_MAX     = (64'd1 << OUT_W) - 1;

  typedef struct packed {
    logic [OUT_W-1:0] b_pos;
    logic [OUT_W-1:0] b_neg;
    logic             clipped;
  } weights_t;

  typedef struct {
    logic [DATA_W-1:0] here;
    logic [DATA_W-1:0] prev;
    bit                typed;
    weights_t          want;
  } row_t;

  logic              clk = 0, rst = 1, start = 0, cfg_valid = 0;
  logic [DATA_W-1:0] v_here = '0, v_prev = '0;
  logic [BAND_W-1:0] cfg_data = '0;
  logic              busy, cfg_ready, done, clipped;
  logic [OUT_W-1:0]  b_pos, b_neg;

  weights_t    pending_weights[$];
  logic [63:0] band_now = 0;
  bit          row_typed = 0;
  weights_t    row_want;
  int          errors = 0, checked = 0, cycles = 0, idle_pct = 0;

  bernoulli_edge_weights_core DUT (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // floor(a*b / 2^56)
  function automatic logic [63:0] mul_fx(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[119:56];
  endfunction

  // smaller Bernoulli weight for |x| = t > 0, Q.FRAC_W
  function automatic logic [63:0] bern_small(logic [63:0] t);
    logic [63:0] tp, n, r, term, d, e, den, num, q, rem;
    int k;
    if (t >= (64'd48 << FRAC_W)) return 0;
    tp = t << (56 - FRAC_W);
    n = tp / LN2_FX;
    r = tp - n * LN2_FX;
    d = 0;
    term = r;
    for (k = 1; k < 64 && term != 0; k++) begin
      if (k % 2) d = d + term;
      else d = d - term;
      term = mul_fx(term, r) / (k + 1);
    end
    e = (n >= 64) ? 64'd0 : ((ONE_FX - d) >> n);
    den = (n == 0) ? d : (ONE_FX - e);
    if (den == 0) return UNITY;
    num = mul_fx(tp, e);
    q = num / den;
    rem = num % den;
    for (k = 0; k <= FRAC_W; k++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q[0] = 1'b1;
      end
    end
    return (q + 1) >> 1;
  endfunction

  function automatic weights_t edge_weights(logic [DATA_W-1:0] here, logic [DATA_W-1:0] prev);
    longint      x, xmax, xmin;
    logic [63:0] t, bs, bp, bn;
    bit          clip;
    weights_t    w;
    xmax = (longint'(1) <<< (DATA_W - 1)) - 1;
    xmin = -xmax - 1;
    x = longint'($signed(here)) - longint'($signed(prev));
    clip = 0;
    if (x > xmax) begin
      x = xmax;
      clip = 1;
    end
    if (x < xmin) begin
      x = xmin;
      clip = 1;
    end
    t = (x < 0) ? 64'(-x) : 64'(x);
    if (t <= band_now) begin
      bp = UNITY;
      bn = UNITY;
    end else begin
      bs = bern_small(t);
      if (x > 0) begin
        bp = bs;
        bn = bs + t;
      end else begin
        bp = bs + t;
        bn = bs;
      end
    end
    if (bp > OUT_MAX) begin
      bp = OUT_MAX;
      clip = 1;
    end
    if (bn > OUT_MAX) begin
      bn = OUT_MAX;
      clip = 1;
    end
    w.b_pos = bp[OUT_W-1:0];
    w.b_neg = bn[OUT_W-1:0];
    w.clipped = clip;
    return w;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, checked);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_bernoulli_edge_weights_core: done, errors");
      $finish;
    end
  end

  // word accepted: predict; result strobe: check against oldest prediction
  always @(posedge clk) begin
    weights_t w;
    if (!rst && start && !busy)
      pending_weights.push_back(row_typed ? row_want : edge_weights(v_here, v_prev));
    if (done) begin
      if (pending_weights.size() == 0) begin
        report_mismatch("unexpected result word", 1, 0);
      end else begin
        w = pending_weights.pop_front();
        if (b_pos !== w.b_pos) report_mismatch("b_pos", b_pos, w.b_pos);
        if (b_neg !== w.b_neg) report_mismatch("b_neg", b_neg, w.b_neg);
        if (clipped !== w.clipped) report_mismatch("clipped", clipped, w.clipped);
        checked++;
      end
    end
  end

  task automatic send_word(logic [DATA_W-1:0] here, logic [DATA_W-1:0] prev,
                           bit typed, weights_t want);
    bit go;
    do begin
      @(negedge clk);
      row_typed = typed;
      row_want = want;
      go = $urandom_range(99) >= idle_pct;
      start = go;
      v_here = here;
      v_prev = prev;
      @(posedge clk);
    end while (!(go && !busy));
  endtask

  task automatic drain();
    @(negedge clk);
    start = 0;
    while (pending_weights.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_band(logic [BAND_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    band_now = val;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic logic [DATA_W-1:0] rand_word();
    return DATA_W'($urandom());
  endfunction

  task automatic random_phase(int n);
    logic [DATA_W-1:0] p, h;
    int diff;
    repeat (n) begin
      p = rand_word();
      case ($urandom_range(3))
        0: h = rand_word();
        1: begin
          diff = $urandom_range(600) - 300;
          h = p + DATA_W'(diff);
        end
        2: begin
          diff = $urandom_range(49 << FRAC_W) - (49 << (FRAC_W - 1));
          h = p + DATA_W'(2 * diff);
        end
        default: begin
          diff = int'(band_now) + $urandom_range(4) - 2;
          h = $urandom_range(1) ? p + DATA_W'(diff) : p - DATA_W'(diff);
        end
      endcase
      send_word(h, p, 1'b0, '0);
    end
  endtask

  localparam logic [DATA_W-1:0] VMAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] VMIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] CUT  = DATA_W'(48) << FRAC_W;

  row_t directed[] = '{
    '{24'd0, 24'd0, 1, '{23'd65536, 23'd65536, 1'b0}},
    '{VMAX, VMIN, 1, '{23'd0, OUT_W'(OUT_MAX), 1'b1}},
    '{VMIN, VMAX, 1, '{OUT_W'(OUT_MAX), 23'd0, 1'b1}},
    '{VMAX, 24'd0, 1, '{23'd0, OUT_W'(OUT_MAX), 1'b0}},
    '{VMIN, 24'd0, 1, '{OUT_W'(OUT_MAX), 23'd0, 1'b1}},
    '{VMAX, VMAX, 1, '{23'd65536, 23'd65536, 1'b0}},
    '{CUT, 24'd0, 1, '{23'd0, 23'(CUT), 1'b0}},
    '{24'd0, CUT, 1, '{23'(CUT), 23'd0, 1'b0}},
    '{CUT - 24'd1, 24'd0, 0, '{0, 0, 0}},
    '{24'd1, 24'd0, 0, '{0, 0, 0}},
    '{24'd0, 24'd1, 0, '{0, 0, 0}},
    '{24'd32768, 24'd0, 0, '{0, 0, 0}},
    '{24'd65536, 24'd0, 0, '{0, 0, 0}},
    '{24'd0, 24'd65536, 0, '{0, 0, 0}},
    '{24'd327680, 24'd0, 0, '{0, 0, 0}},
    '{24'hEC0000, 24'd0, 0, '{0, 0, 0}},
    '{24'hFFFFFF, 24'd0, 0, '{0, 0, 0}},
    '{24'h555555, 24'hAAAAAA, 0, '{0, 0, 0}}
  };

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    idle_pct = 27;
    foreach (directed[i]) begin
      send_word(directed[i].here, directed[i].prev, directed[i].typed, directed[i].want);
    end
    drain();
    row_typed = 0;

    write_band(8'd255);
    random_phase(PHASE_WORDS);
    drain();

    idle_pct = 61;
    write_band(BAND_W'($urandom_range(254, 1)));
    random_phase(PHASE_WORDS);
    drain();

    idle_pct = 0;
    write_band(8'd0);
    random_phase(PHASE_WORDS);
    drain();

    $display("covered %0d result words: directed extremes and clamps, then random", checked);
    $display("differences under near-zero bands of 255, mid-range and 0, with sender gaps");
    if (errors == 0) $display("tb_bernoulli_edge_weights_core: done, clean");
    else $display("tb_bernoulli_edge_weights_core: done, errors");
    $finish;
  end

endmodule
